### rtl/modem_response_matcher_macros.svh
// Assertion macros shared by the modem response matcher checkers.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef MODEM_RESPONSE_MATCHER_MACROS_SVH
`define MODEM_RESPONSE_MATCHER_MACROS_SVH

// Same-cycle implication.
`define MRM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("modem_response_matcher assertion failed");

// Next-cycle implication.
`define MRM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("modem_response_matcher assertion failed");

`endif

### rtl/mrm_pkg.sv
// Shared types, constants and helper functions of the modem response matcher.
// Used by every RTL file of the block; depends on nothing else.
`timescale 1ns / 1ps

package mrm_pkg;

    localparam int RING_DEPTH  = 2048;
    localparam int MAX_PATTERN = 15;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int TAIL_W      = RING_AW + 1;

    localparam logic [7:0] LINE_FEED = 8'h0A;

    localparam logic [1:0] STATUS_RUN = 2'd0;
    localparam logic [1:0] STATUS_OK  = 2'd1;
    localparam logic [1:0] STATUS_ERR = 2'd2;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_NEW  = 1'b1;

    localparam logic [2:0] CFG_OK_LOW   = 3'd0;
    localparam logic [2:0] CFG_OK_HIGH  = 3'd1;
    localparam logic [2:0] CFG_OK_LEN   = 3'd2;
    localparam logic [2:0] CFG_ERR_LOW  = 3'd3;
    localparam logic [2:0] CFG_ERR_HIGH = 3'd4;
    localparam logic [2:0] CFG_ERR_LEN  = 3'd5;
    localparam logic [2:0] CFG_WAIT_RET = 3'd6;
    localparam logic [2:0] CFG_PAGE_LIM = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic       rx_error;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        transaction_end;
        logic        capture_valid;
        logic [10:0] capture_index;
        logic [11:0] tail_index;
        logic [15:0] error_count;
        logic [15:0] byte_count;
    } t_out_item;

    typedef struct packed {
        logic [119:0] ok_pattern;
        logic [3:0]   ok_length;
        logic [119:0] error_pattern;
        logic [3:0]   error_length;
        logic         wait_for_return;
        logic         page_load;
        logic [8:0]   page_value;
    } t_cfg;

    function automatic logic [7:0] pattern_byte(logic [119:0] pat, logic [3:0] k);
        logic [7:0] b;
        b = 8'h00;
        if (k != 4'd15) begin
            b = pat[{k, 3'b000} +: 8];
        end
        return b;
    endfunction

    function automatic logic [3:0] clamp_len(logic [3:0] n);
        logic [3:0] r;
        r = n;
        if (n > 4'(MAX_PATTERN)) begin
            r = 4'(MAX_PATTERN);
        end
        return r;
    endfunction

endpackage

### rtl/mrm_cfg_regs.sv
// Configuration register file of the modem response matcher.
// Depends on mrm_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps

module mrm_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_wdata,
    output mrm_pkg::t_cfg     o_cfg
);

    logic [63:0] r_ok_low;
    logic [55:0] r_ok_high;
    logic [3:0]  r_ok_len;
    logic [63:0] r_err_low;
    logic [55:0] r_err_high;
    logic [3:0]  r_err_len;
    logic        r_wait_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_low   <= '0;
            r_ok_high  <= '0;
            r_ok_len   <= '0;
            r_err_low  <= '0;
            r_err_high <= '0;
            r_err_len  <= '0;
            r_wait_ret <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mrm_pkg::CFG_OK_LOW:   r_ok_low   <= i_cfg_wdata;
                mrm_pkg::CFG_OK_HIGH:  r_ok_high  <= i_cfg_wdata[55:0];
                mrm_pkg::CFG_OK_LEN:   r_ok_len   <= i_cfg_wdata[3:0];
                mrm_pkg::CFG_ERR_LOW:  r_err_low  <= i_cfg_wdata;
                mrm_pkg::CFG_ERR_HIGH: r_err_high <= i_cfg_wdata[55:0];
                mrm_pkg::CFG_ERR_LEN:  r_err_len  <= i_cfg_wdata[3:0];
                mrm_pkg::CFG_WAIT_RET: r_wait_ret <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // The page limit is not kept here: a write loads the page budget in the core.
    always_comb begin
        o_cfg.ok_pattern      = {r_ok_high, r_ok_low};
        o_cfg.ok_length       = r_ok_len;
        o_cfg.error_pattern   = {r_err_high, r_err_low};
        o_cfg.error_length    = r_err_len;
        o_cfg.wait_for_return = r_wait_ret;
        o_cfg.page_load       = i_cfg_we && (i_cfg_index == mrm_pkg::CFG_PAGE_LIM);
        o_cfg.page_value      = i_cfg_wdata[8:0];
    end

endmodule

### rtl/mrm_core.sv
// Matching, capture and counter state of the modem response matcher, with the
// result register. Depends on mrm_pkg for types, constants and helpers.
`timescale 1ns / 1ps

module mrm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrm_pkg::t_cfg       i_cfg,
    input  logic                i_item_valid,
    input  mrm_pkg::t_in_item   i_item,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mrm_pkg::t_out_item  o_out_data
);

    logic [3:0]                  r_ok_idx, n_ok_idx;
    logic [3:0]                  r_err_idx, n_err_idx;
    logic [1:0]                  r_status, n_status;
    logic                        r_end, n_end;
    logic [mrm_pkg::TAIL_W-1:0]  r_tail, n_tail;
    logic signed [8:0]           r_pages, n_pages;
    logic [15:0]                 r_err_cnt, n_err_cnt;
    logic [15:0]                 r_byte_cnt, n_byte_cnt;
    logic                        r_out_valid;
    mrm_pkg::t_out_item          r_out, n_out;

    logic                        take;
    logic [3:0]                  ok_len;
    logic [3:0]                  err_len;
    logic [4:0]                  ok_inc;
    logic [4:0]                  err_inc;
    logic                        cap_valid;
    logic [mrm_pkg::RING_AW-1:0] cap_index;
    logic [7:0]                  b;

    assign take        = i_item_valid && (!r_out_valid || i_out_ready);
    assign o_take      = take;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign ok_len  = mrm_pkg::clamp_len(i_cfg.ok_length);
    assign err_len = mrm_pkg::clamp_len(i_cfg.error_length);
    assign ok_inc  = {1'b0, r_ok_idx} + 5'd1;
    assign err_inc = {1'b0, r_err_idx} + 5'd1;
    assign b       = i_item.rx_byte;

    always_comb begin
        n_ok_idx   = r_ok_idx;
        n_err_idx  = r_err_idx;
        n_status   = r_status;
        n_end      = r_end;
        n_tail     = r_tail;
        n_pages    = r_pages;
        n_err_cnt  = r_err_cnt;
        n_byte_cnt = r_byte_cnt;
        cap_valid  = 1'b0;
        cap_index  = '0;

        if (i_item.kind == mrm_pkg::KIND_NEW) begin
            n_ok_idx   = '0;
            n_err_idx  = '0;
            n_status   = mrm_pkg::STATUS_RUN;
            n_end      = 1'b0;
            n_tail     = '0;
            n_byte_cnt = '0;
        end else begin
            if (r_tail >= mrm_pkg::TAIL_W'(mrm_pkg::RING_DEPTH)) begin
                n_tail = '0;
                if (r_pages > 9'sd0) begin
                    n_pages = r_pages - 9'sd1;
                    if (r_pages == 9'sd1) begin
                        n_status = mrm_pkg::STATUS_OK;
                    end
                end
            end

            if (ok_len != 4'd0) begin
                if (i_cfg.wait_for_return && (n_status == mrm_pkg::STATUS_OK)) begin
                    if (b == mrm_pkg::LINE_FEED) begin
                        n_end = 1'b1;
                    end
                end else if (b != mrm_pkg::pattern_byte(i_cfg.ok_pattern, r_ok_idx)) begin
                    n_ok_idx = '0;
                end else if (ok_inc >= {1'b0, ok_len}) begin
                    if (!i_cfg.wait_for_return) begin
                        n_end = 1'b1;
                    end
                    n_status = mrm_pkg::STATUS_OK;
                    n_ok_idx = '0;
                end else begin
                    n_ok_idx = ok_inc[3:0];
                end
            end

            if (err_len != 4'd0) begin
                if (n_status == mrm_pkg::STATUS_ERR) begin
                    if (b == mrm_pkg::LINE_FEED) begin
                        n_end = 1'b1;
                    end
                end else if (b != mrm_pkg::pattern_byte(i_cfg.error_pattern, r_err_idx)) begin
                    n_err_idx = '0;
                end else if (err_inc >= {1'b0, err_len}) begin
                    n_status  = mrm_pkg::STATUS_ERR;
                    n_err_idx = '0;
                end else begin
                    n_err_idx = err_inc[3:0];
                end
            end

            if (n_pages != 9'sd0) begin
                cap_valid = 1'b1;
                cap_index = n_tail[mrm_pkg::RING_AW-1:0];
                n_tail    = n_tail + mrm_pkg::TAIL_W'(1);
                if (r_byte_cnt != 16'hFFFF) begin
                    n_byte_cnt = r_byte_cnt + 16'd1;
                end
            end

            if (i_item.rx_error && (r_err_cnt != 16'hFFFF)) begin
                n_err_cnt = r_err_cnt + 16'd1;
            end
        end

        n_out.status          = n_status;
        n_out.transaction_end = n_end;
        n_out.capture_valid   = cap_valid;
        n_out.capture_index   = 11'(cap_index);
        n_out.tail_index      = 12'(n_tail);
        n_out.error_count     = n_err_cnt;
        n_out.byte_count      = n_byte_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_idx    <= '0;
            r_err_idx   <= '0;
            r_status    <= mrm_pkg::STATUS_RUN;
            r_end       <= 1'b0;
            r_tail      <= '0;
            r_pages     <= -9'sd1;
            r_err_cnt   <= '0;
            r_byte_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_ok_idx   <= n_ok_idx;
                r_err_idx  <= n_err_idx;
                r_status   <= n_status;
                r_end      <= n_end;
                r_tail     <= n_tail;
                r_err_cnt  <= n_err_cnt;
                r_byte_cnt <= n_byte_cnt;
            end
            if (i_cfg.page_load) begin
                r_pages <= i_cfg.page_value;
            end else if (take) begin
                r_pages <= n_pages;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule

### rtl/modem_response_matcher.sv
// Modem response matcher top level: input register, configuration registers
// and the matching core. Depends on mrm_pkg, mrm_cfg_regs and mrm_core.
//
// The input channel carries one transfer per received byte, or a command that
// starts a new transaction. Each input transfer yields exactly one result
// transfer on the output channel with the status, the sticky end flag, the
// capture position in the 2048-byte ring and the saturating counters.
// Both channels use valid and ready. An input transfer is taken into the
// input register; the core then updates its state and loads the result
// register once the result register is empty or its result is being taken.
// Throughput is one transfer per cycle while the receiver keeps ready high.
// The input register and the result register are separate, so
// a new transfer is accepted while a finished result still waits.
// When the receiver holds ready low, the result stays unchanged and the input
// register fills; then input ready drops until the result is taken.
// Reset clears match state, status, ring tail and counters and sets the page
// budget to unlimited. Configuration writes take effect at once; the user
// must make them only while no transfer is in flight, which the block does
// not enforce. Writing the page limit reloads the page budget.
`timescale 1ns / 1ps

module modem_response_matcher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mrm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mrm_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_wdata
);

    logic               r_in_valid;
    mrm_pkg::t_in_item  r_in_item;
    logic               take;
    mrm_pkg::t_cfg      cfg;

    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    mrm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mrm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (r_in_valid),
        .i_item       (r_in_item),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

### rtl/mrm_checker.sv
// Port-level checker of the modem response matcher, bound to the top level.
// Depends on mrm_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`include "modem_response_matcher_macros.svh"

module mrm_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  mrm_pkg::t_out_item  o_out_data
);

    logic        status_known;
    logic        out_capture;
    logic        out_no_capture;
    logic [11:0] next_tail;

    assign status_known   = (o_out_data.status == mrm_pkg::STATUS_RUN) ||
                            (o_out_data.status == mrm_pkg::STATUS_OK)  ||
                            (o_out_data.status == mrm_pkg::STATUS_ERR);
    assign out_capture    = o_out_valid && o_out_data.capture_valid;
    assign out_no_capture = o_out_valid && !o_out_data.capture_valid;
    assign next_tail      = {1'b0, o_out_data.capture_index} + 12'd1;

    `MRM_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `MRM_ASSERT_IMP(a_status_code, o_out_valid, status_known)
    `MRM_ASSERT_IMP(a_no_capture_index, out_no_capture, o_out_data.capture_index == 11'd0)
    `MRM_ASSERT_IMP(a_capture_tail, out_capture, o_out_data.tail_index == next_tail)
    `MRM_ASSERT_IMP(a_end_has_status, o_out_valid && o_out_data.transaction_end, o_out_data.status != mrm_pkg::STATUS_RUN)

endmodule

bind modem_response_matcher mrm_checker u_mrm_checker (.*);
